// File: sv/mprf_pkg.sv
// Shared types, constants and command codes for the page framebuffer fill unit.
`timescale 1ns / 1ps

package mprf_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 128;
    localparam int ROWS_DEF    = 64;

    // Command codes
    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Byte masks
    localparam logic [7:0] FULL_MASK = 8'hff;
    localparam logic [7:0] LOW_ONES [8] = '{
        8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f, 8'hff
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FILL_DRAIN,
        ST_RD,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

// File: sv/mprf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/mono_page_rect_fill_unit.sv
// Top level: rectangle fill, byte read and clear engine over a paged framebuffer.
//
//  channel   signals                                     direction   beat when
//  --------  ------------------------------------------  ----------  -------------------------
//  input     in_valid, in_stall, cmd,x,y,width,height,page  in       in_valid && !in_stall
//  result    out_valid, out_stall, read_data, status      out        out_valid && !out_stall
//  config    fill_color_we, fill_color                    in         fill_color_we
//
// One command at a time through a single read-modify-write loop on the frame RAM.
// A fill walks each covered page and column once; a clear sweeps the whole RAM;
// an empty or off-screen fill and other commands go straight to DONE.
// After reset the RAM is swept to zero before the first beat is taken. The next
// command is taken while a result waits in the output register; a result stalled
// there holds the sequencer in DONE.
`timescale 1ns / 1ps

module mono_page_rect_fill_unit
    import mprf_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       fill_color_we,
    input  logic       fill_color,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [6:0] x,
    input  logic [5:0] y,
    input  logic [7:0] width,
    input  logic [6:0] height,
    input  logic [2:0] page,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       status
);

    localparam int PAGES  = (ROWS + 7) / 8;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int DEPTH  = PAGES * (1 << COL_W);
    localparam int ADDR_W = $clog2(DEPTH);

    state_t state_reg, state_next;

    logic              fill_color_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  col_last_reg, col_last_next;
    logic [PG_W-1:0]   pg_reg, pg_next;
    logic [PG_W-1:0]   y_pg_reg, y_pg_next;
    logic [PG_W-1:0]   last_pg_reg, last_pg_next;
    logic [2:0]        y_lo_reg, y_lo_next;
    logic [2:0]        last_lo_reg, last_lo_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              clr_cmd_reg, clr_cmd_next;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        wr_mask_reg;
    logic [7:0]        res_data_reg, res_data_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        read_data_reg;
    logic              status_reg;

    logic              in_beat;
    logic              out_load;
    logic              start_off;
    logic              rect_empty;
    logic              read_ok;
    logic              pg_at_last;
    logic              col_at_last;
    logic              clr_at_last;
    logic [8:0]        col_sum;
    logic [7:0]        row_sum;
    logic [7:0]        row_last;
    logic [2:0]        mask_lo;
    logic [2:0]        mask_hi;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] rd_addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    mprf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Command decode on the incoming beat
    assign in_beat    = in_valid && !in_stall;
    assign start_off  = ({2'b00, x} >= 9'(COLUMNS)) || ({2'b00, y} >= 8'(ROWS));
    assign rect_empty = (width == 8'd0) || (height == 7'd0);
    assign read_ok    = ({2'b00, x} < 9'(COLUMNS)) && ({2'b00, page} < 5'(PAGES));

    // Clipped far corner of the rectangle
    assign col_sum  = {2'b00, x} + {1'b0, width} - 9'd1;
    assign row_sum  = {2'b00, y} + {1'b0, height} - 8'd1;
    assign row_last = (row_sum > 8'(ROWS - 1)) ? 8'(ROWS - 1) : row_sum;

    // Walk position
    assign pg_at_last  = (pg_reg == last_pg_reg);
    assign col_at_last = (col_reg == col_last_reg);
    assign clr_at_last = (clr_reg == ADDR_W'(DEPTH - 1));

    // Byte mask of the current page
    assign mask_lo = (pg_reg == y_pg_reg) ? y_lo_reg : 3'd0;
    assign mask_hi = pg_at_last ? last_lo_reg : 3'd7;
    assign mask    = LOW_ONES[mask_hi - mask_lo] << mask_lo;

    assign rd_addr  = ADDR_W'({pg_reg, col_reg});
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (cmd)
                        CMD_FILL:  state_next = (start_off || rect_empty) ? ST_DONE : ST_FILL;
                        CMD_READ:  state_next = read_ok ? ST_RD : ST_DONE;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL:
            begin
                if (pg_at_last && col_at_last)
                begin
                    state_next = ST_FILL_DRAIN;
                end
            end
            ST_FILL_DRAIN: state_next = ST_DONE;
            ST_RD:         state_next = ST_RD_WAIT;
            ST_RD_WAIT:    state_next = ST_DONE;
            ST_CLEAR:
            begin
                if (clr_at_last)
                begin
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // State-driven outputs: handshake and RAM write port
    always_comb
    begin
        in_stall  = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = fill_color_reg ? (ram_rdata | wr_mask_reg) : (ram_rdata & ~wr_mask_reg);
        unique case (state_reg)
            ST_IDLE:       in_stall = 1'b0;
            ST_FILL:       ram_we   = wr_pend_reg;
            ST_FILL_DRAIN: ram_we   = wr_pend_reg;
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
            end
            default:       in_stall = 1'b1;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        col_next        = col_reg;
        col_last_next   = col_last_reg;
        pg_next         = pg_reg;
        y_pg_next       = y_pg_reg;
        last_pg_next    = last_pg_reg;
        y_lo_next       = y_lo_reg;
        last_lo_next    = last_lo_reg;
        clr_next        = clr_reg;
        clr_cmd_next    = clr_cmd_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;

        if (state_reg == ST_IDLE && in_beat)
        begin
            res_data_next   = 8'd0;
            res_status_next = 1'b0;
            clr_next        = '0;
            clr_cmd_next    = 1'b1;
            col_next        = COL_W'(x);
            col_last_next   = (col_sum > 9'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : COL_W'(col_sum);
            y_pg_next       = PG_W'(y >> 3);
            pg_next         = PG_W'(y >> 3);
            last_pg_next    = PG_W'(row_last >> 3);
            y_lo_next       = y[2:0];
            last_lo_next    = row_last[2:0];
            case (cmd)
                CMD_FILL: res_status_next = start_off;
                CMD_READ:
                begin
                    res_status_next = !read_ok;
                    pg_next         = PG_W'(page);
                end
                default:  res_status_next = 1'b0;
            endcase
        end
        else if (state_reg == ST_FILL)
        begin
            if (pg_at_last)
            begin
                pg_next  = y_pg_reg;
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                pg_next = pg_reg + PG_W'(1);
            end
        end
        else if (state_reg == ST_RD_WAIT)
        begin
            res_data_next = ram_rdata;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clr_next = clr_reg + ADDR_W'(1);
        end
    end

    // Result register, parts the sequencer from the result channel
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            clr_cmd_reg    <= 1'b0;
            fill_color_reg <= 1'b1;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_cmd_reg   <= clr_cmd_next;
            wr_pend_reg   <= (state_reg == ST_FILL);
            out_valid_reg <= out_valid_next;
            if (fill_color_we)
            begin
                fill_color_reg <= fill_color;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        col_last_reg   <= col_last_next;
        pg_reg         <= pg_next;
        y_pg_reg       <= y_pg_next;
        last_pg_reg    <= last_pg_next;
        y_lo_reg       <= y_lo_next;
        last_lo_reg    <= last_lo_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        wr_addr_reg    <= rd_addr;
        wr_mask_reg    <= mask;
        if (out_load)
        begin
            read_data_reg <= res_data_reg;
            status_reg    <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // A fill step always covers at least one row of its byte
    a_fill_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (mask != 8'd0))
        else $error("empty mask during fill");

    // The write that follows a fill read targets the byte just read
    a_fill_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |=> (wr_pend_reg && wr_addr_reg == $past(rd_addr)))
        else $error("write-back address does not follow read");

    // The walk never passes the clipped corner
    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (pg_reg <= last_pg_reg && col_reg <= col_last_reg))
        else $error("fill walk out of rectangle");

    // A new result only comes from the DONE state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside DONE");

    // No beat is taken while a fill or a clear is still at work
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL || state_reg == ST_CLEAR) |-> in_stall)
        else $error("beat accepted during a sweep");

endmodule
